@@ design/ssc_pkg.sv @@
// Shared types, codes, reset values and commutation tables of the six-step commutator.
package ssc_pkg;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_DRIVE = 2'd1;
    localparam logic [1:0] MODE_REGEN = 2'd2;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_BLANK = 2'd1;
    localparam logic [1:0] PH_WAIT  = 2'd2;
    localparam logic [1:0] PH_DELAY = 2'd3;

    localparam logic [1:0] CFG_STALL_LIMIT     = 2'd0;
    localparam logic [1:0] CFG_DRIVE_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_BRAKE_THRESHOLD = 2'd2;

    localparam logic [15:0] STALL_LIMIT_RST     = 16'd24576;
    localparam logic [7:0]  DRIVE_THRESHOLD_RST = 8'd128;
    localparam logic [7:0]  BRAKE_THRESHOLD_RST = 8'd64;

    typedef struct packed {
        logic [7:0] mag;
        logic [1:0] mode;
    } t_throttle;

    typedef struct packed {
        logic [2:0] high_side;
        logic [2:0] low_side;
        logic [2:0] brake_switch;
        logic       running_led;
        logic       drive_led;
        logic       regen_led;
    } t_drive;

    function automatic logic [2:0] src_phase_bit(input logic [2:0] s);
        case (s)
            3'd0, 3'd1: src_phase_bit = 3'b001;
            3'd2, 3'd3: src_phase_bit = 3'b010;
            3'd4, 3'd5: src_phase_bit = 3'b100;
            default:    src_phase_bit = 3'b000;
        endcase
    endfunction

    function automatic logic [2:0] ret_phase_bit(input logic [2:0] s);
        case (s)
            3'd0, 3'd5: ret_phase_bit = 3'b010;
            3'd1, 3'd2: ret_phase_bit = 3'b100;
            3'd3, 3'd4: ret_phase_bit = 3'b001;
            default:    ret_phase_bit = 3'b000;
        endcase
    endfunction

    function automatic logic [2:0] cmp_mask(input logic [2:0] s);
        case (s)
            3'd0, 3'd3: cmp_mask = 3'b100;
            3'd1, 3'd4: cmp_mask = 3'b010;
            3'd2, 3'd5: cmp_mask = 3'b001;
            default:    cmp_mask = 3'b000;
        endcase
    endfunction

    function automatic logic [2:0] cmp_base(input logic [2:0] s);
        case (s)
            3'd0:    cmp_base = 3'b100;
            3'd2:    cmp_base = 3'b001;
            3'd4:    cmp_base = 3'b010;
            default: cmp_base = 3'b000;
        endcase
    endfunction

endpackage

@@ design/ssc_throttle.sv @@
// Throttle classifier holding the latched throttle magnitude and mode.
module ssc_throttle (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_adc_valid,
    input  logic [7:0]            i_adc_sample,
    input  logic [7:0]            i_drive_threshold,
    input  logic [7:0]            i_brake_threshold,
    output ssc_pkg::t_throttle    o_throttle
);

    ssc_pkg::t_throttle r_thr;
    ssc_pkg::t_throttle n_thr;
    logic [7:0] w_diff;
    logic [8:0] w_dbl;

    always_comb begin
        n_thr  = r_thr;
        w_diff = 8'd0;
        if (i_adc_sample > i_drive_threshold) begin
            w_diff = i_adc_sample - i_drive_threshold;
        end else if (i_adc_sample < i_brake_threshold) begin
            w_diff = i_brake_threshold - i_adc_sample;
        end
        w_dbl = {w_diff, 1'b0};
        if (i_adc_valid) begin
            n_thr.mag = w_dbl[8] ? 8'hFF : w_dbl[7:0];
            if (i_adc_sample > i_drive_threshold) begin
                n_thr.mode = ssc_pkg::MODE_DRIVE;
            end else if (i_adc_sample < i_brake_threshold) begin
                n_thr.mode = ssc_pkg::MODE_REGEN;
            end else begin
                n_thr.mode = ssc_pkg::MODE_OFF;
            end
        end
    end

    assign o_throttle = n_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.mag  <= 8'd0;
            r_thr.mode <= ssc_pkg::MODE_OFF;
        end else if (i_en) begin
            r_thr <= n_thr;
        end
    end

endmodule

@@ design/ssc_core.sv @@
// Commutation sequencer: step state, timing stages, on-time and switch pattern.
module ssc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [2:0]         i_comparator_bits,
    input  logic               i_start_button,
    input  ssc_pkg::t_throttle i_throttle,
    input  logic [15:0]        i_stall_limit,
    output ssc_pkg::t_drive    o_drive
);

    logic [2:0]  r_step,     n_step;
    logic [1:0]  r_phase,    n_phase;
    logic [15:0] r_tick,     n_tick;
    logic [15:0] r_period,   n_period;
    logic [15:0] r_on_time,  n_on_time;
    logic [1:0]  r_applied,  n_applied;
    logic [15:0] r_next_on,  n_next_on;
    logic [1:0]  r_next_mode, n_next_mode;
    logic        r_running,  n_running;
    logic        r_skip,     n_skip;
    logic [15:0] r_delay,    n_delay;
    logic        r_btn_prev, n_btn_prev;

    logic [15:0] w_tick;
    logic        w_enable;
    logic        w_commutate;
    logic [23:0] w_product;
    logic [17:0] w_sum;

    assign w_product = r_period * i_throttle.mag;
    assign w_sum     = 18'(r_period[15:3]) + 18'(r_period[15:2]) + 18'(w_tick);

    always_comb begin
        n_step      = r_step;
        n_phase     = r_phase;
        n_period    = r_period;
        n_on_time   = r_on_time;
        n_applied   = r_applied;
        n_next_on   = r_next_on;
        n_next_mode = r_next_mode;
        n_running   = r_running;
        n_skip      = r_skip;
        n_delay     = r_delay;
        n_btn_prev  = i_start_button;
        w_tick      = r_tick;
        w_enable    = 1'b0;
        w_commutate = 1'b0;

        if ((i_start_button != r_btn_prev) && r_skip) begin
            if (i_start_button) begin
                n_skip = 1'b0;
            end else begin
                n_running = 1'b1;
            end
        end

        if (n_phase == ssc_pkg::PH_START) begin
            w_tick    = 16'd0;
            n_applied = r_next_mode;
            n_on_time = r_next_on;
            if (n_running) begin
                if (r_period > i_stall_limit) begin
                    n_running = 1'b0;
                    w_enable  = 1'b0;
                end else begin
                    w_enable = 1'b1;
                end
            end else begin
                w_enable = i_start_button;
            end
            if (w_enable) begin
                n_next_on   = w_product[23:8];
                n_next_mode = i_throttle.mode;
            end else begin
                n_next_on   = 16'd0;
                n_next_mode = ssc_pkg::MODE_OFF;
            end
            n_phase = ssc_pkg::PH_BLANK;
        end
        if (n_phase == ssc_pkg::PH_BLANK && w_tick >= {1'b0, r_period[15:1]}) begin
            n_skip  = 1'b1;
            n_phase = ssc_pkg::PH_WAIT;
        end
        if (n_phase == ssc_pkg::PH_WAIT) begin
            if (((i_comparator_bits & ssc_pkg::cmp_mask(r_step)) != ssc_pkg::cmp_base(r_step))
                    || !n_skip) begin
                if (!i_start_button) begin
                    n_delay = (w_sum[17:16] != 2'd0) ? 16'hFFFF : w_sum[15:0];
                    n_phase = ssc_pkg::PH_DELAY;
                end else begin
                    w_commutate = 1'b1;
                end
            end
        end
        if (n_phase == ssc_pkg::PH_DELAY && w_tick >= n_delay) begin
            w_commutate = 1'b1;
        end

        o_drive.high_side    = 3'b000;
        o_drive.brake_switch = 3'b000;
        o_drive.low_side     = ssc_pkg::ret_phase_bit(r_step);
        if (!w_commutate && w_tick < n_on_time) begin
            if (n_applied == ssc_pkg::MODE_DRIVE) begin
                o_drive.high_side = ssc_pkg::src_phase_bit(r_step);
            end else if (n_applied == ssc_pkg::MODE_REGEN) begin
                o_drive.brake_switch = ssc_pkg::src_phase_bit(r_step);
            end
        end
        o_drive.running_led = n_running;
        o_drive.drive_led   = (i_throttle.mode == ssc_pkg::MODE_DRIVE);
        o_drive.regen_led   = (i_throttle.mode == ssc_pkg::MODE_REGEN);

        if (w_commutate) begin
            n_period = w_tick;
            n_step   = (r_step >= 3'd5) ? 3'd0 : r_step + 3'd1;
            n_phase  = ssc_pkg::PH_START;
        end

        n_tick = (w_tick != 16'hFFFF) ? w_tick + 16'd1 : w_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 3'd0;
            r_phase     <= ssc_pkg::PH_START;
            r_tick      <= 16'd0;
            r_period    <= 16'd0;
            r_on_time   <= 16'd0;
            r_applied   <= ssc_pkg::MODE_OFF;
            r_next_on   <= 16'd0;
            r_next_mode <= ssc_pkg::MODE_OFF;
            r_running   <= 1'b0;
            r_skip      <= 1'b1;
            r_delay     <= 16'd0;
            r_btn_prev  <= 1'b0;
        end else if (i_en) begin
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_period    <= n_period;
            r_on_time   <= n_on_time;
            r_applied   <= n_applied;
            r_next_on   <= n_next_on;
            r_next_mode <= n_next_mode;
            r_running   <= n_running;
            r_skip      <= n_skip;
            r_delay     <= n_delay;
            r_btn_prev  <= n_btn_prev;
        end
    end

endmodule

@@ design/sensorless_bldc_six_step_commutator.sv @@
// Top level: request input register, configuration registers and result register.
// An accepted tick request is held in the input register; its result is then stored in the result register.
// Throughput: one tick per cycle while the result is taken; the sequencer does a whole tick between the
// input register and the result register.
// Reset: synchronous, active low; all step state, throttle state and configuration
// registers return to their initial values and both pipeline registers empty.
module sensorless_bldc_six_step_commutator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_comparator_bits,
    input  logic        i_start_button,
    input  logic        i_adc_valid,
    input  logic [7:0]  i_adc_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_high_side,
    output logic [2:0]  o_low_side,
    output logic [2:0]  o_brake_switch,
    output logic        o_running_led,
    output logic        o_drive_led,
    output logic        o_regen_led,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    logic [2:0]  r_bits;
    logic        r_button;
    logic        r_adc_valid;
    logic [7:0]  r_adc_sample;
    logic        r_out_valid;
    ssc_pkg::t_drive r_result;
    logic [15:0] r_stall_limit;
    logic [7:0]  r_drive_thr;
    logic [7:0]  r_brake_thr;

    logic               w_adv;
    ssc_pkg::t_throttle w_throttle;
    ssc_pkg::t_drive    w_drive;

    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    ssc_throttle u_throttle (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_adv),
        .i_adc_valid       (r_adc_valid),
        .i_adc_sample      (r_adc_sample),
        .i_drive_threshold (r_drive_thr),
        .i_brake_threshold (r_brake_thr),
        .o_throttle        (w_throttle)
    );

    ssc_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_adv),
        .i_comparator_bits (r_bits),
        .i_start_button    (r_button),
        .i_throttle        (w_throttle),
        .i_stall_limit     (r_stall_limit),
        .o_drive           (w_drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_bits       <= i_comparator_bits;
            r_button     <= i_start_button;
            r_adc_valid  <= i_adc_valid;
            r_adc_sample <= i_adc_sample;
        end
        if (w_adv) begin
            r_result <= w_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall_limit <= ssc_pkg::STALL_LIMIT_RST;
            r_drive_thr   <= ssc_pkg::DRIVE_THRESHOLD_RST;
            r_brake_thr   <= ssc_pkg::BRAKE_THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssc_pkg::CFG_STALL_LIMIT:     r_stall_limit <= i_cfg_data;
                ssc_pkg::CFG_DRIVE_THRESHOLD: r_drive_thr   <= i_cfg_data[7:0];
                ssc_pkg::CFG_BRAKE_THRESHOLD: r_brake_thr   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_high_side    = r_result.high_side;
    assign o_low_side     = r_result.low_side;
    assign o_brake_switch = r_result.brake_switch;
    assign o_running_led  = r_result.running_led;
    assign o_drive_led    = r_result.drive_led;
    assign o_regen_led    = r_result.regen_led;

endmodule

@@ design/ssc_checker.sv @@
// Port-level checker for the six-step commutator and its bind statement.
module ssc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_high_side,
    input logic [2:0] o_low_side,
    input logic [2:0] o_brake_switch,
    input logic       o_drive_led,
    input logic       o_regen_led
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Result request dropped before it was taken.");

    a_one_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(o_low_side))
        else $error("Exactly one low switch must be on.");

    a_no_shoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_high_side & o_low_side) == 3'b000))
        else $error("High and low switch of one phase are both on.");

    a_drive_xor_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_high_side == 3'b000 || o_brake_switch == 3'b000))
        else $error("Drive and brake switches are on together.");

    a_leds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_drive_led && o_regen_led))
        else $error("Drive and regen indications are both on.");

endmodule

bind sensorless_bldc_six_step_commutator ssc_checker u_ssc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_high_side    (o_high_side),
    .o_low_side     (o_low_side),
    .o_brake_switch (o_brake_switch),
    .o_drive_led    (o_drive_led),
    .o_regen_led    (o_regen_led)
);
